### design/afrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrb_pkg
// Shared constants, codes and types of the audio frame ring buffer.
// ----------------------------------------------------------------------------
package afrb_pkg;

    // Frame and ring geometry
    localparam int FRAME_SAMPLES = 48;
    localparam int RING_FRAMES   = 20;
    localparam int FRAME_BYTES   = FRAME_SAMPLES * 2;
    localparam int RING_BYTES    = FRAME_BYTES * RING_FRAMES;
    localparam int PTR_W         = $clog2(RING_BYTES);
    localparam int FILL_W        = PTR_W + 1;
    localparam int CNT_W         = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int ALT_W    = 8;
    localparam int BYTE_W   = 8;

    // Command codes; code 3 is unused and ignored
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALT   = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_HI,
        ST_RD_LO,
        ST_RD_HI,
        ST_RD_DONE,
        ST_UNDER
    } t_state;

    // Load request from the sequencer into the output register
    typedef struct packed {
        logic                load;
        logic [SAMPLE_W-1:0] sample;
        logic                underrun;
        logic                last;
    } t_out_load;

endpackage

### design/afrb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrb_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module afrb_ram #(
    parameter int DEPTH = 960,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/afrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrb_ctrl
// Ring sequencer: owns the pointers and streaming flag, writes pushed bytes
// into the ring and reads frames back two bytes per sample.
// ----------------------------------------------------------------------------
module afrb_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request in
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  logic [afrb_pkg::CMD_W-1:0]        i_cmd,
    input  logic [afrb_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [afrb_pkg::ALT_W-1:0]        i_alt,
    // output register
    input  logic                              i_slot_free,
    output afrb_pkg::t_out_load               o_load,
    // ring memory
    output logic                              o_we,
    output logic [afrb_pkg::PTR_W-1:0]        o_waddr,
    output logic [afrb_pkg::BYTE_W-1:0]       o_wdata,
    output logic                              o_re,
    output logic [afrb_pkg::PTR_W-1:0]        o_raddr,
    input  logic [afrb_pkg::BYTE_W-1:0]       i_rdata
);
    import afrb_pkg::*;

    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_wp, n_wp;
    logic [PTR_W-1:0]    r_rp, n_rp;
    logic                r_streaming, n_streaming;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [BYTE_W-1:0]   r_lo, n_lo;
    logic [BYTE_W-1:0]   r_hi_byte, n_hi_byte;

    logic                accept;
    logic [PTR_W-1:0]    wp_next;
    logic [PTR_W-1:0]    rp_next;
    logic                ring_full;
    logic [FILL_W-1:0]   fill;
    logic                frame_ready;
    logic                cnt_last;

    // Pointer wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(RING_BYTES - 1)) begin
            res = '0;
        end else begin
            res = p + 1'b1;
        end
        return res;
    endfunction

    assign accept      = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == ST_IDLE);
    assign wp_next     = ptr_inc(r_wp);
    assign rp_next     = ptr_inc(r_rp);
    // one slot always stays empty
    assign ring_full   = (wp_next == r_rp);
    assign cnt_last    = (r_cnt == CNT_W'(FRAME_SAMPLES - 1));

    // Buffered byte count
    always_comb begin
        if (r_wp >= r_rp) begin
            fill = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            fill = {1'b0, r_wp} + FILL_W'(RING_BYTES) - {1'b0, r_rp};
        end
    end
    assign frame_ready = (fill >= FILL_W'(FRAME_BYTES));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_PUSH && r_streaming && !ring_full) begin
                        n_state = ST_PUSH_HI;
                    end else if (i_cmd == CMD_FRAME) begin
                        n_state = frame_ready ? ST_RD_LO : ST_UNDER;
                    end
                end
            end
            ST_PUSH_HI: n_state = ST_IDLE;
            ST_RD_LO:   n_state = ST_RD_HI;
            ST_RD_HI:   n_state = ST_RD_DONE;
            ST_RD_DONE: begin
                if (i_slot_free) begin
                    n_state = cnt_last ? ST_IDLE : ST_RD_LO;
                end
            end
            ST_UNDER: begin
                if (i_slot_free && cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_streaming = r_streaming;
        n_cnt       = r_cnt;
        n_lo        = r_lo;
        n_hi_byte   = r_hi_byte;
        o_we        = 1'b0;
        o_waddr     = r_wp;
        o_wdata     = i_sample[BYTE_W-1:0];
        o_re        = 1'b0;
        o_raddr     = r_rp;
        o_load      = '{load: 1'b0, sample: '0, underrun: 1'b0, last: cnt_last};
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    case (i_cmd)
                        CMD_PUSH: begin
                            // full on the low byte drops the whole sample
                            if (r_streaming && !ring_full) begin
                                o_we      = 1'b1;
                                n_wp      = wp_next;
                                n_hi_byte = i_sample[SAMPLE_W-1:BYTE_W];
                            end
                        end
                        CMD_ALT: n_streaming = (i_alt != '0);
                        default: ;
                    endcase
                end
            end
            ST_PUSH_HI: begin
                o_wdata = r_hi_byte;
                if (!ring_full) begin
                    o_we = 1'b1;
                    n_wp = wp_next;
                end
            end
            ST_RD_LO: begin
                o_re = 1'b1;
                n_rp = rp_next;
            end
            ST_RD_HI: begin
                o_re = 1'b1;
                n_rp = rp_next;
                n_lo = i_rdata;
            end
            ST_RD_DONE: begin
                if (i_slot_free) begin
                    o_load.load   = 1'b1;
                    o_load.sample = {i_rdata, r_lo};
                    n_cnt         = r_cnt + 1'b1;
                end
            end
            ST_UNDER: begin
                if (i_slot_free) begin
                    o_load.load     = 1'b1;
                    o_load.underrun = 1'b1;
                    n_cnt           = r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_streaming <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_streaming <= n_streaming;
            r_cnt       <= n_cnt;
        end
    end

    // Byte holding registers
    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi_byte <= n_hi_byte;
    end

endmodule

### design/audio_frame_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_frame_ring_buffer
// Byte ring between a sample source and a frame reader: pushes write two
// bytes, frame requests stream one frame of samples or flagged silence.
//
//   channel   dir   contents
//   s_axis    in    tdata {alt, sample}, tuser cmd
//   m_axis    out   tdata sample_out, tuser underrun, tlast last
//
// Push: when stored, low then high byte go through the single RAM write
// port; a push dropped while stopped or on a full ring leaves the sequencer idle.
// A setting change or unused command also leaves the sequencer idle.
// Frame: each sample takes two reads of the single RAM read port plus an
// output load, and back-pressure holds it off; an underrun frame takes only
// the output loads.
// Reset clears pointers and streaming at once; the ring needs no clearing.
// A stalled output holds its sample and pauses the frame sequencer.
// ----------------------------------------------------------------------------
module audio_frame_ring_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] sample, [23:16] alt
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    output logic [0:0]  m_axis_tuser,   // [0] underrun
    output logic        m_axis_tlast
);
    import afrb_pkg::*;

    t_out_load           load;
    logic                slot_free;
    logic                we;
    logic [PTR_W-1:0]    waddr;
    logic [BYTE_W-1:0]   wdata;
    logic                re;
    logic [PTR_W-1:0]    raddr;
    logic [BYTE_W-1:0]   rdata;

    logic                r_m_valid;
    logic [SAMPLE_W-1:0] r_m_data;
    logic                r_m_under;
    logic                r_m_last;

    afrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_alt       (s_axis_tdata[SAMPLE_W+ALT_W-1:SAMPLE_W]),
        .i_slot_free (slot_free),
        .o_load      (load),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    afrb_ram #(
        .DEPTH (RING_BYTES),
        .WIDTH (BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Output register: free when empty or being taken this cycle
    assign slot_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load.load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load.load) begin
            r_m_data  <= load.sample;
            r_m_under <= load.underrun;
            r_m_last  <= load.last;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_under;
    assign m_axis_tlast    = r_m_last;

endmodule

### design/afrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrb_checker
// Port-level checks of the audio frame ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module afrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import afrb_pkg::*;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Silence frames carry zero samples
    a_under_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("underrun sample not zero");

    // A frame request holds off the next request
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_FRAME
            |=> !s_axis_tready)
        else $error("request taken while frame starts");

endmodule

bind audio_frame_ring_buffer afrb_checker u_afrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### bench/tb_audio_frame_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_frame_ring_buffer
// Self-checking bench for the audio frame ring buffer. A directed table
// covers reset silence, dropped pushes, extreme samples, the unused command,
// a frame two bytes short and a drain while stopped. A random phase follows,
// built mostly from push bursts and frame requests. Every frame word is
// checked against a byte-level model of the ring. Both stream sides idle in
// random bursts.
// ----------------------------------------------------------------------------
module tb_audio_frame_ring_buffer;
    import afrb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 136;
    localparam int CALM_FROM     = 100;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4 * FRAME_SAMPLES + 16;
    localparam int NUM_ROWS      = 22;

    // One word of a frame as it leaves the block
    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                under;
        logic                last;
    } t_frame_word;

    // Directed row: a request repeated rep times, sample stepping by step;
    // silent marks a frame known to come back as flagged silence
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SAMPLE_W-1:0] smp;
        logic [ALT_W-1:0]    alt;
        logic [9:0]          rep;
        logic [SAMPLE_W-1:0] step;
        logic                silent;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // [15:0] sample, [23:16] alt
    logic [1:0]  s_tuser = '0;      // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] sample_out
    logic [0:0]  m_tuser;           // [0] underrun
    logic        m_tlast;

    // Ring model
    logic [BYTE_W-1:0] ring_bytes [RING_BYTES];
    int unsigned       wr_idx = 0;
    int unsigned       rd_idx = 0;
    bit                stream_on = 1'b0;
    t_frame_word       words_due [$];

    // Bookkeeping
    int mismatches     = 0;
    int words_checked  = 0;
    int frames_full    = 0;
    int frames_silent  = 0;
    int pushes_kept    = 0;
    int pushes_dropped = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    int gap_pct        = 20;
    int stall_pct      = 30;

    t_stim_row plan [NUM_ROWS] = '{
        '{CMD_FRAME,  16'h0000, 8'h00, 10'd1,   16'h0000, 1'b1}, // silence after reset
        '{CMD_PUSH,   16'h7FFF, 8'h00, 10'd1,   16'h0000, 1'b0}, // dropped, not streaming
        '{CMD_FRAME,  16'h0000, 8'h00, 10'd1,   16'h0000, 1'b1},
        '{CMD_UNUSED, 16'hFFFF, 8'hFF, 10'd1,   16'h0000, 1'b0}, // ignored code
        '{CMD_ALT,    16'hFFFF, 8'h01, 10'd1,   16'h0000, 1'b0}, // smallest nonzero setting
        '{CMD_PUSH,   16'h8000, 8'h00, 10'd1,   16'h0000, 1'b0},
        '{CMD_PUSH,   16'h7FFF, 8'hFF, 10'd1,   16'h0000, 1'b0},
        '{CMD_PUSH,   16'h0000, 8'h00, 10'd1,   16'h0000, 1'b0},
        '{CMD_PUSH,   16'hFFFF, 8'h00, 10'd1,   16'h0000, 1'b0},
        '{CMD_PUSH,   16'h0100, 8'h5A, 10'd43,  16'h0101, 1'b0},
        '{CMD_FRAME,  16'h0000, 8'h00, 10'd1,   16'h0000, 1'b1}, // two bytes short
        '{CMD_PUSH,   16'hA55A, 8'h00, 10'd1,   16'h0000, 1'b0},
        '{CMD_FRAME,  16'h0000, 8'h00, 10'd1,   16'h0000, 1'b0}, // exactly one frame
        '{CMD_ALT,    16'hFFFF, 8'h00, 10'd1,   16'h0000, 1'b0}, // stop streaming
        '{CMD_PUSH,   16'h1234, 8'h00, 10'd3,   16'h1111, 1'b0},
        '{CMD_ALT,    16'h0000, 8'hFF, 10'd1,   16'h0000, 1'b0}, // largest setting
        '{CMD_PUSH,   16'h0001, 8'h00, 10'd146, 16'h0203, 1'b0}, // three frames and a bit
        '{CMD_FRAME,  16'hFFFF, 8'hFF, 10'd2,   16'h0000, 1'b0},
        '{CMD_ALT,    16'h0000, 8'h00, 10'd1,   16'h0000, 1'b0},
        '{CMD_FRAME,  16'h0000, 8'h00, 10'd3,   16'h0000, 1'b0}, // drain while stopped
        '{CMD_ALT,    16'h0000, 8'h80, 10'd1,   16'h0000, 1'b0},
        '{CMD_UNUSED, 16'h0000, 8'h00, 10'd1,   16'h0000, 1'b0}
    };

    audio_frame_ring_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Ring model helpers
    function automatic int unsigned ring_adv(input int unsigned p);
        return (p + 1 >= RING_BYTES) ? 0 : p + 1;
    endfunction

    // Writes one byte unless that would close the gap slot
    function automatic bit store_byte(input logic [BYTE_W-1:0] b);
        if (ring_adv(wr_idx) == rd_idx)
            return 1'b0;
        ring_bytes[wr_idx] = b;
        wr_idx = ring_adv(wr_idx);
        return 1'b1;
    endfunction

    task automatic queue_silence();
        int k;
        for (k = 0; k < FRAME_SAMPLES; k++)
            words_due.push_back('{smp: '0, under: 1'b1, last: (k == FRAME_SAMPLES - 1)});
    endtask

    // Updates the ring model for one accepted request and queues its words
    task automatic predict_request(input logic [CMD_W-1:0] cmd,
                                   input logic [SAMPLE_W-1:0] smp,
                                   input logic [ALT_W-1:0] alt);
        int unsigned       fill;
        int                k;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        case (cmd)
            CMD_PUSH: begin
                if (stream_on) begin
                    pushes_kept++;
                    if (store_byte(smp[7:0]))
                        void'(store_byte(smp[15:8]));
                end else begin
                    pushes_dropped++;
                end
            end
            CMD_ALT: begin
                stream_on = (alt != '0);
            end
            CMD_FRAME: begin
                fill = (wr_idx + RING_BYTES - rd_idx) % RING_BYTES;
                if (fill >= FRAME_BYTES) begin
                    frames_full++;
                    for (k = 0; k < FRAME_SAMPLES; k++) begin
                        lo = ring_bytes[rd_idx];
                        rd_idx = ring_adv(rd_idx);
                        hi = ring_bytes[rd_idx];
                        rd_idx = ring_adv(rd_idx);
                        words_due.push_back('{smp: {hi, lo}, under: 1'b0,
                                              last: (k == FRAME_SAMPLES - 1)});
                    end
                end else begin
                    frames_silent++;
                    queue_silence();
                end
            end
            default: begin
            end
        endcase
    endtask

    // Drives one request and waits for it to be taken; called at a clock edge
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [SAMPLE_W-1:0] smp,
                                input logic [ALT_W-1:0] alt,
                                input bit silent);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {alt, smp};
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!s_tready);
        if (silent) begin
            frames_silent++;
            queue_silence();
        end else begin
            predict_request(cmd, smp, alt);
        end
    endtask

    // Holds the sender back until every queued word has come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (words_due.size() != 0);
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 20;
            default: return 50;
        endcase
    endfunction

    // Output side: ready drops in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 7);
        m_tready <= (stall_left == 0);
    end

    // Word checker
    always @(posedge i_clk) begin : check_words
        t_frame_word got;
        t_frame_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{smp: m_tdata, under: m_tuser[0], last: m_tlast};
            words_checked++;
            if (words_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: expected none, got %h/%b/%b",
                         $time, got.smp, got.under, got.last);
            end else begin
                want = words_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: word mismatch (sample/underrun/last): %s",
                             $time, "expected vs got");
                    $display("    expected %h/%b/%b, got %h/%b/%b",
                             want.smp, want.under, want.last,
                             got.smp, got.under, got.last);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog: no transfer for %0d cycles, %0d words outstanding",
                     $time, IDLE_LIMIT, words_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        t_stim_row           row;
        int                  n;
        int                  j;
        int                  r;
        int                  burst;
        int                  n_rand;
        logic [SAMPLE_W-1:0] smp;
        logic [ALT_W-1:0]    alt;
        n_rand = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (n = 0; n < NUM_ROWS; n++) begin
            row = plan[n];
            for (j = 0; j < row.rep; j++)
                send_request(row.cmd, SAMPLE_W'(row.smp + row.step * j), row.alt,
                             row.silent);
        end
        wait_for_drain();

        // Random phase: push bursts and frame requests, with some noise
        while (n_rand < RANDOM_ITEMS) begin
            if (n_rand >= CALM_FROM) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                burst = $urandom_range(20, 60);
                for (j = 0; j < burst && n_rand < RANDOM_ITEMS; j++) begin
                    if (n_rand >= CALM_FROM) begin
                        gap_pct   = 0;
                        stall_pct = 0;
                    end
                    send_request(CMD_PUSH, SAMPLE_W'($urandom()), ALT_W'($urandom()),
                                 1'b0);
                    n_rand++;
                end
            end else if (r < 82) begin
                if ($urandom_range(0, 3) == 0)
                    wait_for_drain();
                send_request(CMD_FRAME, SAMPLE_W'($urandom()), ALT_W'($urandom()), 1'b0);
                n_rand++;
            end else if (r < 90) begin
                alt = ($urandom_range(0, 2) == 0) ? '0 : ALT_W'($urandom_range(1, 255));
                send_request(CMD_ALT, SAMPLE_W'($urandom()), alt, 1'b0);
                n_rand++;
            end else if (r < 96) begin
                smp = SAMPLE_W'($urandom());
                send_request(CMD_UNUSED, smp, ALT_W'($urandom()), 1'b0);
                n_rand++;
            end else begin
                repeat ($urandom_range(2, 4)) begin
                    send_request(CMD_FRAME, SAMPLE_W'($urandom()), ALT_W'($urandom()),
                                 1'b0);
                    n_rand++;
                end
            end
        end

        // Let the last frame finish, then watch for stray words
        s_tvalid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d pushes stored, %0d pushes dropped while stopped",
                 pushes_kept, pushes_dropped);
        $display("covered %0d frames from the ring, %0d silent frames, %0d words checked",
                 frames_full, frames_silent, words_checked);
        if (mismatches == 0 && words_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
